FILE: src/dtc_report_bam_framer_assert.svh
// Assertion macros for the trouble report framer.
`ifndef DTC_REPORT_BAM_FRAMER_ASSERT_SVH
`define DTC_REPORT_BAM_FRAMER_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent.
`define DTCBF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define DTCBF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/dtcbf_pkg.sv
// Shared types and constants of the trouble report framer.
package dtcbf_pkg;

    localparam int IDX_W      = 4;
    localparam int SPN_W      = 19;
    localparam int FMI_W      = 5;
    localparam int OCC_W      = 16;
    localparam int ENTRY_W    = SPN_W + FMI_W + OCC_W;
    localparam int S_TDATA_W  = 48;
    localparam int PAYLOAD_W  = 64;
    localparam int KIND_W     = 2;
    localparam int TICKS_W    = 13;
    localparam int CNT_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int REC_W      = 32;

    localparam logic [KIND_W-1:0] KIND_SINGLE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ANNOUNCE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DATA     = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP    = 2'd1;

    localparam logic [TICKS_W-1:0] PERIOD_RESET = 13'd100;
    localparam logic [TICKS_W-1:0] GAP_RESET    = 13'd10;
    localparam logic [CNT_W-1:0]   COUNT_RESET  = 16'd1000;
    localparam logic [CNT_W-1:0]   COUNT_MAX    = 16'hFFFF;

    localparam logic [7:0] OCC_SAT     = 8'h7F;
    localparam logic [7:0] BAM_CONTROL = 8'h20;
    localparam logic [7:0] PGN_LOW     = 8'hCA;
    localparam logic [7:0] PGN_MID     = 8'hFE;
    localparam logic [7:0] FILL_BYTE   = 8'hFF;
    localparam logic [7:0] ZERO_BYTE   = 8'h00;
    localparam int         FRAME_BYTES = 7;

    typedef struct packed {
        logic              entry_wr;
        logic              tick_inc;
        logic              data_fetch;
        logic              session_end;
        logic              walk_start;
        logic              ent_read;
        logic              ent_capture;
        logic              ent_next;
        logic              rec_push;
        logic              flush;
        logic              out_load;
        logic [KIND_W-1:0] out_kind;
    } cmd_t;

    typedef struct packed {
        logic session_active;
        logic gap_due;
        logic more_frames;
        logic period_due;
        logic ent_failed;
        logic ent_last;
        logic rec_last;
        logic multi;
        logic out_free;
    } status_t;

endpackage

FILE: src/dtc_report_bam_framer.sv
// Top level of the periodic trouble report framer with broadcast transport.
// Each input item either writes one trouble entry (tuser low) or is a ten
// millisecond tick (tuser high). A tick that sends nothing goes from the tick
// state back to idle; a tick that releases a stored transport data frame
// fetches it, then waits in the emit state for the output register to empty.
// A tick that starts a report walks the entry table, reading and checking each
// entry, and pushes the record of each failed entry one record byte per cycle
// into the frame assembler before it emits a single or an announce frame.
// Configuration writes are always taken; the output register lets a new item in
// while the last result waits.
`include "dtc_report_bam_framer_assert.svh"

module dtc_report_bam_framer #(
    parameter int NUM_ENTRIES = 16,
    parameter int MAX_PACKETS = 10
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // entry_index[3:0], spn[22:4], fmi[27:23], occurrences[43:28], failed[44]
    input  logic [dtcbf_pkg::S_TDATA_W-1:0]       s_axis_tdata,
    // action[0]
    input  logic                                  s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // payload[63:0]
    output logic [dtcbf_pkg::PAYLOAD_W-1:0]       m_axis_tdata,
    // frame_kind[1:0]
    output logic [dtcbf_pkg::KIND_W-1:0]          m_axis_tuser,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [dtcbf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dtcbf_pkg::TICKS_W-1:0]         cfg_data
);

    dtcbf_pkg::cmd_t    cmd;
    dtcbf_pkg::status_t status;

    logic cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    dtcbf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_axis_tvalid),
        .s_action (s_axis_tuser),
        .s_ready  (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    dtcbf_dpath #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .MAX_PACKETS (MAX_PACKETS)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_entry_index (s_axis_tdata[3:0]),
        .s_spn         (s_axis_tdata[22:4]),
        .s_fmi         (s_axis_tdata[27:23]),
        .s_occurrences (s_axis_tdata[43:28]),
        .s_failed      (s_axis_tdata[44]),
        .cfg_valid     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .m_ready       (m_axis_tready),
        .m_valid       (m_axis_tvalid),
        .m_kind        (m_axis_tuser),
        .m_payload     (m_axis_tdata)
    );

    `DTCBF_ASSERT_SAME(a_load_free, aclk, aresetn, cmd.out_load, status.out_free, "result loaded over a waiting item")
    `DTCBF_ASSERT_SAME(a_fetch_live, aclk, aresetn, cmd.data_fetch, (status.session_active && status.more_frames && status.gap_due), "data frame fetched outside a due session")
    `DTCBF_ASSERT_NEXT(a_tick_busy, aclk, aresetn, (s_axis_tvalid && s_axis_tready && s_axis_tuser), !s_axis_tready, "item taken while a tick is in work")
    `DTCBF_ASSERT_SAME(a_kind_code, aclk, aresetn, m_axis_tvalid, (m_axis_tuser == dtcbf_pkg::KIND_SINGLE || m_axis_tuser == dtcbf_pkg::KIND_ANNOUNCE || m_axis_tuser == dtcbf_pkg::KIND_DATA), "unknown frame kind offered")

endmodule

FILE: src/dtcbf_ctrl.sv
// Sequencer for ticks, table walks and frame output of the trouble report framer.
module dtcbf_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic                       s_action,
    output logic                       s_ready,
    input  dtcbf_pkg::status_t         status,
    output dtcbf_pkg::cmd_t            cmd
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_TICK  = 8'b0000_0010,
        ST_RD    = 8'b0000_0100,
        ST_CHK   = 8'b0000_1000,
        ST_PUSH  = 8'b0001_0000,
        ST_DONE  = 8'b0010_0000,
        ST_FLUSH = 8'b0100_0000,
        ST_EMIT  = 8'b1000_0000
    } state_t;

    state_t                           state_reg;
    state_t                           state_next;
    logic [dtcbf_pkg::KIND_W-1:0]     kind_reg;
    logic [dtcbf_pkg::KIND_W-1:0]     kind_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_action) begin
                        cmd.tick_inc = 1'b1;
                        state_next   = ST_TICK;
                    end else begin
                        cmd.entry_wr = 1'b1;
                    end
                end
            end
            ST_TICK: begin
                if (status.session_active && !status.gap_due) begin
                    state_next = ST_IDLE;
                end else if (status.session_active && status.more_frames) begin
                    cmd.data_fetch = 1'b1;
                    kind_next      = dtcbf_pkg::KIND_DATA;
                    state_next     = ST_EMIT;
                end else begin
                    cmd.session_end = status.session_active;
                    if (status.period_due) begin
                        cmd.walk_start = 1'b1;
                        state_next     = ST_RD;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_RD: begin
                cmd.ent_read = 1'b1;
                state_next   = ST_CHK;
            end
            ST_CHK: begin
                if (status.ent_failed) begin
                    cmd.ent_capture = 1'b1;
                    state_next      = ST_PUSH;
                end else if (status.ent_last) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.ent_next = 1'b1;
                    state_next   = ST_RD;
                end
            end
            ST_PUSH: begin
                cmd.rec_push = 1'b1;
                if (status.rec_last) begin
                    if (status.ent_last) begin
                        state_next = ST_DONE;
                    end else begin
                        cmd.ent_next = 1'b1;
                        state_next   = ST_RD;
                    end
                end
            end
            ST_DONE: begin
                if (status.multi) begin
                    state_next = ST_FLUSH;
                end else begin
                    kind_next  = dtcbf_pkg::KIND_SINGLE;
                    state_next = ST_EMIT;
                end
            end
            ST_FLUSH: begin
                cmd.flush  = 1'b1;
                kind_next  = dtcbf_pkg::KIND_ANNOUNCE;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                cmd.out_kind = kind_reg;
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            kind_reg  <= dtcbf_pkg::KIND_SINGLE;
        end else begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

endmodule

FILE: src/dtcbf_dpath.sv
// Entry table, tick counters, frame assembler, frame store and output register.
module dtcbf_dpath #(
    parameter int NUM_ENTRIES = 16,
    parameter int MAX_PACKETS = 10
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  dtcbf_pkg::cmd_t                      cmd,
    output dtcbf_pkg::status_t                   status,
    input  logic [dtcbf_pkg::IDX_W-1:0]          s_entry_index,
    input  logic [dtcbf_pkg::SPN_W-1:0]          s_spn,
    input  logic [dtcbf_pkg::FMI_W-1:0]          s_fmi,
    input  logic [dtcbf_pkg::OCC_W-1:0]          s_occurrences,
    input  logic                                 s_failed,
    input  logic                                 cfg_valid,
    input  logic [dtcbf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dtcbf_pkg::TICKS_W-1:0]        cfg_data,
    input  logic                                 m_ready,
    output logic                                 m_valid,
    output logic [dtcbf_pkg::KIND_W-1:0]         m_kind,
    output logic [dtcbf_pkg::PAYLOAD_W-1:0]      m_payload
);

    localparam int EW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int FW = $clog2(NUM_ENTRIES + 1);
    localparam int PW = $clog2(MAX_PACKETS);
    localparam int CW = $clog2(MAX_PACKETS + 1);
    localparam int LW = FW + 2;

    logic [dtcbf_pkg::TICKS_W-1:0]   period_ticks_reg, period_ticks_next;
    logic [dtcbf_pkg::TICKS_W-1:0]   gap_ticks_reg, gap_ticks_next;
    logic [dtcbf_pkg::CNT_W-1:0]     period_cnt_reg, period_cnt_next;
    logic [dtcbf_pkg::CNT_W-1:0]     gap_cnt_reg, gap_cnt_next;
    logic                            session_reg, session_next;
    logic [CW-1:0]                   total_reg, total_next;
    logic [CW-1:0]                   sent_reg, sent_next;
    logic [NUM_ENTRIES-1:0]          failed_reg, failed_next;
    logic [EW-1:0]                   idx_reg, idx_next;
    logic [FW-1:0]                   fail_cnt_reg, fail_cnt_next;
    logic [CW-1:0]                   frame_cnt_reg, frame_cnt_next;
    logic [2:0]                      slot_reg, slot_next;
    logic [1:0]                      byte_cnt_reg, byte_cnt_next;
    logic [6:0][7:0]                 fbuf_reg, fbuf_next;
    logic [dtcbf_pkg::REC_W-1:0]     rec_reg, rec_next;
    logic [dtcbf_pkg::REC_W-1:0]     first_rec_reg, first_rec_next;
    logic                            ent_failed_reg;
    logic [dtcbf_pkg::ENTRY_W-1:0]   ent_data_reg;
    logic [dtcbf_pkg::PAYLOAD_W-1:0] store_rd_reg;
    logic                            out_valid_reg, out_valid_next;
    logic [dtcbf_pkg::KIND_W-1:0]    out_kind_reg, out_kind_next;
    logic [dtcbf_pkg::PAYLOAD_W-1:0] out_data_reg, out_data_next;

    logic [dtcbf_pkg::ENTRY_W-1:0]   entry_mem [NUM_ENTRIES];
    logic [dtcbf_pkg::PAYLOAD_W-1:0] frame_mem [MAX_PACKETS];

    logic [6:0]                      wr_idx_wide;
    logic                            wr_in_range;
    logic [EW-1:0]                   wr_addr;
    logic [dtcbf_pkg::SPN_W-1:0]     ent_spn;
    logic [dtcbf_pkg::FMI_W-1:0]     ent_fmi;
    logic [dtcbf_pkg::OCC_W-1:0]     ent_occ;
    logic [7:0]                      occ_byte;
    logic [dtcbf_pkg::REC_W-1:0]     record;
    logic [7:0]                      seq;
    logic                            frame_room;
    logic                            frame_we;
    logic [dtcbf_pkg::PAYLOAD_W-1:0] frame_word;
    logic                            flush_inc;
    logic [LW-1:0]                   len_short;
    logic [15:0]                     len_word;
    logic [dtcbf_pkg::PAYLOAD_W-1:0] single_word;
    logic [dtcbf_pkg::PAYLOAD_W-1:0] announce_word;

    assign wr_idx_wide = 7'(s_entry_index);
    assign wr_in_range = wr_idx_wide < 7'(NUM_ENTRIES);
    assign wr_addr     = wr_idx_wide[EW-1:0];

    assign ent_spn  = ent_data_reg[dtcbf_pkg::SPN_W-1:0];
    assign ent_fmi  = ent_data_reg[dtcbf_pkg::SPN_W +: dtcbf_pkg::FMI_W];
    assign ent_occ  = ent_data_reg[dtcbf_pkg::SPN_W + dtcbf_pkg::FMI_W +: dtcbf_pkg::OCC_W];
    assign occ_byte = (ent_occ >= 16'(dtcbf_pkg::OCC_SAT)) ? dtcbf_pkg::OCC_SAT : ent_occ[7:0];
    assign record   = {occ_byte, ent_spn[18:16], ent_fmi, ent_spn[15:8], ent_spn[7:0]};

    assign seq        = 8'(frame_cnt_reg) + 8'd1;
    assign frame_room = frame_cnt_reg < CW'(MAX_PACKETS);
    assign flush_inc  = (slot_reg != 3'd0) && frame_room;

    assign len_short = {fail_cnt_reg, 2'b10};
    assign len_word  = 16'(len_short);

    assign single_word = {dtcbf_pkg::FILL_BYTE, dtcbf_pkg::FILL_BYTE,
                          (fail_cnt_reg == '0) ? 32'd0 : first_rec_reg,
                          dtcbf_pkg::FILL_BYTE, dtcbf_pkg::ZERO_BYTE};
    assign announce_word = {dtcbf_pkg::ZERO_BYTE, dtcbf_pkg::PGN_MID, dtcbf_pkg::PGN_LOW,
                            dtcbf_pkg::FILL_BYTE, 8'(total_reg), len_word[15:8],
                            len_word[7:0], dtcbf_pkg::BAM_CONTROL};

    always_comb begin
        period_ticks_next = period_ticks_reg;
        gap_ticks_next    = gap_ticks_reg;
        period_cnt_next   = period_cnt_reg;
        gap_cnt_next      = gap_cnt_reg;
        session_next      = session_reg;
        total_next        = total_reg;
        sent_next         = sent_reg;
        failed_next       = failed_reg;
        idx_next          = idx_reg;
        fail_cnt_next     = fail_cnt_reg;
        frame_cnt_next    = frame_cnt_reg;
        slot_next         = slot_reg;
        byte_cnt_next     = byte_cnt_reg;
        fbuf_next         = fbuf_reg;
        rec_next          = rec_reg;
        first_rec_next    = first_rec_reg;
        out_valid_next    = out_valid_reg;
        out_kind_next     = out_kind_reg;
        out_data_next     = out_data_reg;
        frame_we          = 1'b0;
        frame_word        = {fbuf_reg, seq};

        if (cfg_valid) begin
            case (cfg_index)
                dtcbf_pkg::CFG_PERIOD: period_ticks_next = cfg_data;
                dtcbf_pkg::CFG_GAP:    gap_ticks_next    = cfg_data;
                default: begin
                end
            endcase
        end

        if (cmd.tick_inc) begin
            if (period_cnt_reg != dtcbf_pkg::COUNT_MAX) begin
                period_cnt_next = period_cnt_reg + 16'd1;
            end
            if (gap_cnt_reg != dtcbf_pkg::COUNT_MAX) begin
                gap_cnt_next = gap_cnt_reg + 16'd1;
            end
        end
        if (cmd.data_fetch || cmd.session_end || cmd.walk_start) begin
            gap_cnt_next = '0;
        end
        if (cmd.data_fetch) begin
            sent_next = sent_reg + CW'(1);
        end
        if (cmd.session_end) begin
            session_next = 1'b0;
            total_next   = '0;
            sent_next    = '0;
        end

        if (cmd.entry_wr && wr_in_range) begin
            failed_next[wr_addr] = s_failed;
        end

        // Preload the stream header: zero lamp byte, then the reserved byte.
        if (cmd.walk_start) begin
            period_cnt_next = '0;
            idx_next        = '0;
            fail_cnt_next   = '0;
            frame_cnt_next  = '0;
            slot_next       = 3'd2;
            fbuf_next       = '1;
            fbuf_next[0]    = dtcbf_pkg::ZERO_BYTE;
        end
        if (cmd.ent_next) begin
            idx_next = idx_reg + EW'(1);
        end
        if (cmd.ent_capture) begin
            rec_next      = record;
            fail_cnt_next = fail_cnt_reg + FW'(1);
            byte_cnt_next = 2'd0;
            if (fail_cnt_reg == '0) begin
                first_rec_next = record;
            end
        end

        if (cmd.rec_push) begin
            rec_next      = {8'h00, rec_reg[dtcbf_pkg::REC_W-1:8]};
            byte_cnt_next = byte_cnt_reg + 2'd1;
            if (slot_reg == 3'(dtcbf_pkg::FRAME_BYTES - 1)) begin
                frame_word = {rec_reg[7:0], fbuf_reg[5:0], seq};
                frame_we   = frame_room;
                if (frame_room) begin
                    frame_cnt_next = frame_cnt_reg + CW'(1);
                end
                fbuf_next = '1;
                slot_next = 3'd0;
            end else begin
                fbuf_next[slot_reg] = rec_reg[7:0];
                slot_next           = slot_reg + 3'd1;
            end
        end

        if (cmd.flush) begin
            frame_we     = flush_inc;
            total_next   = flush_inc ? frame_cnt_reg + CW'(1) : frame_cnt_reg;
            sent_next    = '0;
            session_next = 1'b1;
        end

        if (cmd.out_load) begin
            out_valid_next = 1'b1;
            out_kind_next  = cmd.out_kind;
            case (cmd.out_kind)
                dtcbf_pkg::KIND_DATA:     out_data_next = store_rd_reg;
                dtcbf_pkg::KIND_ANNOUNCE: out_data_next = announce_word;
                default:                  out_data_next = single_word;
            endcase
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_ticks_reg <= dtcbf_pkg::PERIOD_RESET;
            gap_ticks_reg    <= dtcbf_pkg::GAP_RESET;
            period_cnt_reg   <= dtcbf_pkg::COUNT_RESET;
            gap_cnt_reg      <= dtcbf_pkg::COUNT_RESET;
            session_reg      <= 1'b0;
            total_reg        <= '0;
            sent_reg         <= '0;
            failed_reg       <= '0;
            fail_cnt_reg     <= '0;
            frame_cnt_reg    <= '0;
            slot_reg         <= '0;
            byte_cnt_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            period_ticks_reg <= period_ticks_next;
            gap_ticks_reg    <= gap_ticks_next;
            period_cnt_reg   <= period_cnt_next;
            gap_cnt_reg      <= gap_cnt_next;
            session_reg      <= session_next;
            total_reg        <= total_next;
            sent_reg         <= sent_next;
            failed_reg       <= failed_next;
            fail_cnt_reg     <= fail_cnt_next;
            frame_cnt_reg    <= frame_cnt_next;
            slot_reg         <= slot_next;
            byte_cnt_reg     <= byte_cnt_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg       <= idx_next;
        fbuf_reg      <= fbuf_next;
        rec_reg       <= rec_next;
        first_rec_reg <= first_rec_next;
        out_kind_reg  <= out_kind_next;
        out_data_reg  <= out_data_next;
        if (cmd.ent_read) begin
            ent_failed_reg <= failed_reg[idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.entry_wr && wr_in_range) begin
            entry_mem[wr_addr] <= {s_occurrences, s_fmi, s_spn};
        end
        if (cmd.ent_read) begin
            ent_data_reg <= entry_mem[idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (frame_we) begin
            frame_mem[frame_cnt_reg[PW-1:0]] <= frame_word;
        end
        if (cmd.data_fetch) begin
            store_rd_reg <= frame_mem[sent_reg[PW-1:0]];
        end
    end

    assign status.session_active = session_reg;
    assign status.gap_due        = gap_cnt_reg >= 16'(gap_ticks_reg);
    assign status.more_frames    = sent_reg < total_reg;
    assign status.period_due     = period_cnt_reg >= 16'(period_ticks_reg);
    assign status.ent_failed     = ent_failed_reg;
    assign status.ent_last       = idx_reg == EW'(NUM_ENTRIES - 1);
    assign status.rec_last       = byte_cnt_reg == 2'd3;
    assign status.multi          = fail_cnt_reg > FW'(1);
    assign status.out_free       = !out_valid_reg || m_ready;

    assign m_valid   = out_valid_reg;
    assign m_kind    = out_kind_reg;
    assign m_payload = out_data_reg;

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the trouble report framer, compared against a local framer model.
`timescale 1ns / 1ps

module tb_top;

    localparam int NUM_ENT     = 16;
    localparam int MAX_PKT     = 10;
    localparam int LATENCY     = 150;
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    localparam logic [dtcbf_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd2;
    localparam logic [dtcbf_pkg::TICKS_W-1:0]   TICKS_TOP = '1;

    typedef logic [dtcbf_pkg::IDX_W-1:0] idx_t;
    typedef logic [dtcbf_pkg::SPN_W-1:0] spn_t;
    typedef logic [dtcbf_pkg::FMI_W-1:0] fmi_t;
    typedef logic [dtcbf_pkg::OCC_W-1:0] occ_t;

    typedef struct {
        logic  action;
        idx_t  idx;
        spn_t  spn;
        fmi_t  fmi;
        occ_t  occ;
        logic  failed;
    } item_t;

    typedef struct {
        logic [dtcbf_pkg::KIND_W-1:0]    kind;
        logic [dtcbf_pkg::PAYLOAD_W-1:0] payload;
    } frame_t;

    logic                              aclk          = 1'b0;
    logic                              aresetn       = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [dtcbf_pkg::S_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic                              s_axis_tuser  = 1'b0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [dtcbf_pkg::PAYLOAD_W-1:0]   m_axis_tdata;
    logic [dtcbf_pkg::KIND_W-1:0]      m_axis_tuser;
    logic                              cfg_valid     = 1'b0;
    logic                              cfg_ready;
    logic [dtcbf_pkg::CFG_IDX_W-1:0]   cfg_index     = '0;
    logic [dtcbf_pkg::TICKS_W-1:0]     cfg_data      = '0;

    // framer model state
    spn_t                              ent_spn    [NUM_ENT] = '{default: '0};
    fmi_t                              ent_fmi    [NUM_ENT] = '{default: '0};
    occ_t                              ent_occ    [NUM_ENT] = '{default: '0};
    logic                              ent_failed [NUM_ENT] = '{default: 1'b0};
    logic [dtcbf_pkg::PAYLOAD_W-1:0]   frame_bank [MAX_PKT];
    int                     per_limit         = int'(dtcbf_pkg::PERIOD_RESET);
    int                     gap_limit         = int'(dtcbf_pkg::GAP_RESET);
    int                     tick_since_report = int'(dtcbf_pkg::COUNT_RESET);
    int                     tick_since_frame  = int'(dtcbf_pkg::COUNT_RESET);
    logic                   sess_on           = 1'b0;
    int                     frames_planned    = 0;
    int                     frames_sent       = 0;

    item_t  items_waiting[$];
    frame_t frames_due[$];
    item_t  on_bus;
    int     items_queued = 0;
    int     items_taken  = 0;
    int     mismatches   = 0;
    int     send_idle    = 0;
    int     recv_idle    = 0;
    int     hold_asks    = 0;
    int     hold_seen    = 0;
    int     hold_left    = 0;
    int     quiet        = 0;

    dtc_report_bam_framer #(
        .NUM_ENTRIES(NUM_ENT),
        .MAX_PACKETS(MAX_PKT)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic frame_t start_report();
        logic [7:0]                      strm [NUM_ENT*4+2];
        logic [dtcbf_pkg::PAYLOAD_W-1:0] w;
        frame_t                          f;
        int                              len;
        int                              n;
        int                              pos;
        strm[0] = dtcbf_pkg::ZERO_BYTE;
        strm[1] = dtcbf_pkg::FILL_BYTE;
        len = 2;
        for (int i = 0; i < NUM_ENT; i++) begin
            if (ent_failed[i]) begin
                strm[len]     = ent_spn[i][7:0];
                strm[len + 1] = ent_spn[i][15:8];
                strm[len + 2] = {ent_spn[i][18:16], ent_fmi[i]};
                strm[len + 3] = (ent_occ[i] >= occ_t'(dtcbf_pkg::OCC_SAT)) ?
                                dtcbf_pkg::OCC_SAT : ent_occ[i][7:0];
                len += 4;
            end
        end
        if (len <= 6) begin
            f.kind = dtcbf_pkg::KIND_SINGLE;
            f.payload = {dtcbf_pkg::FILL_BYTE, dtcbf_pkg::FILL_BYTE, 48'h0};
            for (int k = 0; k < len; k++) f.payload[8*k +: 8] = strm[k];
            return f;
        end
        n = (len + 6) / 7;
        if (n > MAX_PKT) n = MAX_PKT;
        for (int p = 0; p < n; p++) begin
            w = '0;
            w[7:0] = 8'(p + 1);
            for (int k = 0; k < dtcbf_pkg::FRAME_BYTES; k++) begin
                pos = p * dtcbf_pkg::FRAME_BYTES + k;
                w[8*(k+1) +: 8] = (pos < len) ? strm[pos] : dtcbf_pkg::FILL_BYTE;
            end
            frame_bank[p] = w;
        end
        frames_planned = n;
        frames_sent = 0;
        sess_on = 1'b1;
        f.kind = dtcbf_pkg::KIND_ANNOUNCE;
        f.payload = {dtcbf_pkg::ZERO_BYTE, dtcbf_pkg::PGN_MID, dtcbf_pkg::PGN_LOW,
                     dtcbf_pkg::FILL_BYTE, 8'(n), 8'(len >> 8), 8'(len),
                     dtcbf_pkg::BAM_CONTROL};
        return f;
    endfunction

    function automatic void step_framer(input item_t it);
        frame_t f;
        int     top;
        top = int'(dtcbf_pkg::COUNT_MAX);
        if (it.action == ACT_WRITE) begin
            ent_spn[it.idx]    = it.spn;
            ent_fmi[it.idx]    = it.fmi;
            ent_occ[it.idx]    = it.occ;
            ent_failed[it.idx] = it.failed;
            return;
        end
        tick_since_report = (tick_since_report >= top) ? top : tick_since_report + 1;
        tick_since_frame  = (tick_since_frame >= top) ? top : tick_since_frame + 1;
        if (sess_on) begin
            if (tick_since_frame < gap_limit) return;
            tick_since_frame = 0;
            if (frames_sent < frames_planned && frames_sent < MAX_PKT) begin
                f.kind = dtcbf_pkg::KIND_DATA;
                f.payload = frame_bank[frames_sent];
                frames_due.push_back(f);
                frames_sent++;
                return;
            end
            sess_on = 1'b0;
            frames_planned = 0;
            frames_sent = 0;
        end
        if (tick_since_report >= per_limit) begin
            tick_since_report = 0;
            tick_since_frame = 0;
            frames_due.push_back(start_report());
        end
    endfunction

    function automatic item_t make_tick();
        item_t it;
        it.action = ACT_TICK;
        it.idx    = idx_t'($urandom);
        it.spn    = spn_t'($urandom);
        it.fmi    = fmi_t'($urandom);
        it.occ    = occ_t'($urandom);
        it.failed = $urandom_range(1) != 0;
        return it;
    endfunction

    function automatic item_t entry_of(input int idx, input int spn, input int fmi,
                                       input int occ, input logic failed);
        item_t it;
        it.action = ACT_WRITE;
        it.idx    = idx_t'(idx);
        it.spn    = spn_t'(spn);
        it.fmi    = fmi_t'(fmi);
        it.occ    = occ_t'(occ);
        it.failed = failed;
        return it;
    endfunction

    function automatic item_t make_entry(input int idx, input int fail_pct);
        item_t it;
        it = entry_of(idx, int'($urandom), int'($urandom), int'($urandom),
                      int'($urandom_range(99)) < fail_pct);
        case ($urandom_range(3))
            0: it.spn = '0;
            1: it.spn = '1;
            default: ;
        endcase
        case ($urandom_range(3))
            0: it.fmi = '0;
            1: it.fmi = '1;
            default: ;
        endcase
        case ($urandom_range(4))
            0: it.occ = '0;
            1: it.occ = '1;
            2: it.occ = occ_t'($urandom_range(124, 130));
            default: ;
        endcase
        return it;
    endfunction

    task automatic offer(input item_t it);
        items_waiting.push_back(it);
        items_queued++;
    endtask

    task automatic run_mix(input int count, input int tick_pct, input int fail_pct);
        for (int i = 0; i < count; i++) begin
            if (int'($urandom_range(99)) < tick_pct) offer(make_tick());
            else offer(make_entry(int'($urandom_range(NUM_ENT - 1)), fail_pct));
        end
    endtask

    task automatic wait_done();
        while (items_taken != items_queued || frames_due.size() != 0) @(posedge aclk);
    endtask

    task automatic settle();
        wait_done();
        repeat (LATENCY) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [dtcbf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dtcbf_pkg::TICKS_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == dtcbf_pkg::CFG_PERIOD) per_limit = int'(val);
        else if (idx == dtcbf_pkg::CFG_GAP) gap_limit = int'(val);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                step_framer(on_bus);
                items_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (items_waiting.size() != 0 && int'($urandom_range(99)) >= send_idle) begin
                    on_bus = items_waiting.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {3'b0, on_bus.failed, on_bus.occ, on_bus.fmi,
                                      on_bus.spn, on_bus.idx};
                    s_axis_tuser  <= on_bus.action;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        frame_t f;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (frames_due.size() == 0) begin
                    $display("%0t: unexpected frame, expected none, got kind %0d payload %h",
                             $time, m_axis_tuser, m_axis_tdata);
                    mismatches++;
                end else begin
                    f = frames_due.pop_front();
                    if (m_axis_tuser !== f.kind) begin
                        $display("%0t: frame kind mismatch, expected %0d, got %0d",
                                 $time, f.kind, m_axis_tuser);
                        mismatches++;
                    end
                    if (m_axis_tdata !== f.payload) begin
                        $display("%0t: payload mismatch, expected %h, got %h",
                                 $time, f.payload, m_axis_tdata);
                        mismatches++;
                    end
                end
            end
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left <= hold_left - 1;
            end else if (hold_seen != hold_asks) begin
                m_axis_tready <= 1'b0;
                hold_seen <= hold_asks;
                hold_left <= HOLD_CYCLES;
            end else begin
                m_axis_tready <= (int'($urandom_range(99)) >= recv_idle);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        send_idle = 29;
        recv_idle = 62;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // empty report, then single record with saturated count
        offer(make_tick());
        offer(entry_of(0, 19'h7FFFF, 5'h1F, 16'hFFFF, 1'b1));
        settle();
        write_reg(dtcbf_pkg::CFG_PERIOD, '0);
        write_reg(CFG_SPARE, TICKS_TOP);
        offer(make_tick());
        offer(entry_of(15, 0, 0, 0, 1'b1));
        offer(entry_of(7, 19'h2AAAA, 5'h15, 126, 1'b1));
        offer(entry_of(3, 19'h55555, 5'h0A, 127, 1'b1));
        // transport sessions back to back, ending into a fresh broadcast
        settle();
        write_reg(dtcbf_pkg::CFG_GAP, '0);
        repeat (8) offer(make_tick());
        offer(entry_of(0, 19'h12345, 5'h03, 128, 1'b0));
        offer(entry_of(7, 19'h2AAAA, 5'h15, 126, 1'b0));
        repeat (5) offer(make_tick());

        settle();
        write_reg(dtcbf_pkg::CFG_PERIOD, TICKS_TOP);
        write_reg(dtcbf_pkg::CFG_GAP, TICKS_TOP);
        run_mix(30, 50, 50);

        // hold the result side while ticks keep arriving
        settle();
        write_reg(dtcbf_pkg::CFG_PERIOD, '0);
        write_reg(dtcbf_pkg::CFG_GAP, '0);
        hold_asks++;
        repeat (80) offer(make_tick());

        for (int mode = 0; mode < 3; mode++) begin
            send_idle = (mode == 0) ? 29 : (mode == 1) ? 62 : 0;
            recv_idle = (mode == 0) ? 62 : (mode == 1) ? 29 : 0;
            for (int k = 0; k < 3; k++) begin
                settle();
                write_reg(dtcbf_pkg::CFG_PERIOD, 13'($urandom_range(0, 24)));
                write_reg(dtcbf_pkg::CFG_GAP, 13'($urandom_range(0, 6)));
                run_mix(105, 65, (k == 0) ? 15 : (k == 1) ? 50 : 90);
            end
        end

        // drain any session, then start one with twelve records
        settle();
        write_reg(dtcbf_pkg::CFG_PERIOD, TICKS_TOP);
        write_reg(dtcbf_pkg::CFG_GAP, '0);
        while (sess_on) begin
            offer(make_tick());
            wait_done();
        end
        for (int i = 0; i < NUM_ENT; i++) offer(make_entry(i, (i < 12) ? 100 : 0));
        settle();
        write_reg(dtcbf_pkg::CFG_PERIOD, 13'd1);
        write_reg(dtcbf_pkg::CFG_GAP, TICKS_TOP);
        offer(make_tick());

        settle();
        if (mismatches == 0 && frames_due.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: dtc_report_bam_framer.f
+incdir+src
src/dtcbf_pkg.sv
src/dtcbf_ctrl.sv
src/dtcbf_dpath.sv
src/dtc_report_bam_framer.sv
test/tb_top.sv
